// ===== rtl/utf8_stream_decoder_unit_assert.svh =====
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define UTF8SD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/utf8sd_pkg.sv =====
// Types and constants shared by the UTF-8 stream decoder modules.
`default_nettype none

package utf8sd_pkg;

   localparam logic [7:0] LEAD6_MASK  = 8'hfe;
   localparam logic [7:0] LEAD6_CODE  = 8'hfc;
   localparam logic [7:0] LEAD5_MASK  = 8'hfc;
   localparam logic [7:0] LEAD5_CODE  = 8'hf8;
   localparam logic [7:0] LEAD4_MASK  = 8'hf8;
   localparam logic [7:0] LEAD4_CODE  = 8'hf0;
   localparam logic [7:0] LEAD3_MASK  = 8'hf0;
   localparam logic [7:0] LEAD3_CODE  = 8'he0;
   localparam logic [7:0] LEAD2_MASK  = 8'he0;
   localparam logic [7:0] LEAD2_CODE  = 8'hc0;

   localparam logic [2:0] OWED_NONE   = 3'd0;
   localparam logic [2:0] OWED_ONE    = 3'd1;
   localparam logic [2:0] OWED_TWO    = 3'd2;
   localparam logic [2:0] OWED_THREE  = 3'd3;
   localparam logic [2:0] OWED_FOUR   = 3'd4;
   localparam logic [2:0] OWED_FIVE   = 3'd5;

   typedef struct packed {
      logic [30:0] code_point;
      logic        truncated;
      logic        final_result;
   } utf8sd_result_type;

   typedef struct packed {
      logic        have;
      logic [2:0]  owed;
      logic [30:0] gathered;
   } utf8sd_step_type;

endpackage

`default_nettype wire

// ===== rtl/utf8sd_decode.sv =====
// Combinational decode of one byte against the current sequence state.
`default_nettype none

module utf8sd_decode (
   input  wire logic [7:0]                   byte_in,
   input  wire logic                         end_of_buffer,
   input  wire logic [2:0]                   owed,
   input  wire logic [30:0]                  gathered,
   output utf8sd_pkg::utf8sd_step_type       step,
   output utf8sd_pkg::utf8sd_result_type     result
);
   import utf8sd_pkg::*;

   logic [30:0] shifted;
   logic [2:0]  owed_less;

   assign shifted   = {gathered[24:0], byte_in[5:0]};
   assign owed_less = owed - OWED_ONE;

   always_comb begin
      step   = '{have: 1'b0, owed: OWED_NONE, gathered: 31'd0};
      result = '{code_point: 31'd0, truncated: 1'b0, final_result: end_of_buffer};
      if (owed == OWED_NONE) begin
         if ((byte_in & LEAD6_MASK) == LEAD6_CODE) begin
            step.owed     = OWED_FIVE;
            step.gathered = {30'd0, byte_in[0]};
         end else if ((byte_in & LEAD5_MASK) == LEAD5_CODE) begin
            step.owed     = OWED_FOUR;
            step.gathered = {29'd0, byte_in[1:0]};
         end else if ((byte_in & LEAD4_MASK) == LEAD4_CODE) begin
            step.owed     = OWED_THREE;
            step.gathered = {28'd0, byte_in[2:0]};
         end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
            step.owed     = OWED_TWO;
            step.gathered = {27'd0, byte_in[3:0]};
         end else if ((byte_in & LEAD2_MASK) == LEAD2_CODE) begin
            step.owed     = OWED_ONE;
            step.gathered = {26'd0, byte_in[4:0]};
         end else begin
            step.have         = 1'b1;
            result.code_point = {23'd0, byte_in};
         end
      end else begin
         step.owed = owed_less;
         if (owed_less == OWED_NONE) begin
            step.have         = 1'b1;
            result.code_point = shifted;
         end else begin
            step.gathered = shifted;
         end
      end
      // drop a partial sequence at the buffer end
      if (!step.have && end_of_buffer) begin
         step.have          = 1'b1;
         step.owed          = OWED_NONE;
         step.gathered      = 31'd0;
         result.code_point  = 31'd0;
         result.truncated   = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/utf8sd_rsp_reg.sv =====
// Result register that holds one decoded word until the consumer takes it.
`default_nettype none

module utf8sd_rsp_reg (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         load,
   input  wire utf8sd_pkg::utf8sd_result_type result,
   output logic                              free,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [30:0]                       rsp_code_point,
   output logic                              rsp_truncated,
   output logic                              rsp_final_result
);
   import utf8sd_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   utf8sd_result_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_code_point   = data_ff.code_point;
   assign rsp_truncated    = data_ff.truncated;
   assign rsp_final_result = data_ff.final_result;

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_decoder_unit.sv =====
// Top level of the UTF-8 stream decoder (original six-byte form).
//
// Takes one byte per word on the req_ channel and gives one 31-bit code point
// on the rsp_ channel for each complete sequence, stray continuation byte,
// ASCII byte or 0xFE/0xFF byte. A byte marked end_of_buffer that leaves a
// sequence unfinished gives a word with truncated set and code point zero.
// One byte is accepted every cycle while the consumer keeps up; a result is
// presented once its byte has passed the input register and its result has been
// loaded into the result register. A result held by the consumer stalls the
// byte behind it in the input register. The rate is set by the update of the
// owed-byte counter and the payload accumulator, which every byte passes
// through in order.
`default_nettype none
`include "utf8_stream_decoder_unit_assert.svh"

module utf8_stream_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic        req_end_of_buffer,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [30:0]      rsp_code_point,
   output logic             rsp_truncated,
   output logic             rsp_final_result
);
   import utf8sd_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        byte_ff;
   logic              last_ff;
   logic [2:0]        owed_ff;
   logic [30:0]       gathered_ff;
   logic              advance;
   logic              out_free;
   logic              req_take;
   utf8sd_step_type   step;
   utf8sd_result_type result;

   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || advance;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         owed_ff     <= OWED_NONE;
         gathered_ff <= 31'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            owed_ff     <= step.owed;
            gathered_ff <= step.gathered;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_byte_in;
         last_ff <= req_end_of_buffer;
      end
   end

   utf8sd_decode u_decode (
      .byte_in       (byte_ff),
      .end_of_buffer (last_ff),
      .owed          (owed_ff),
      .gathered      (gathered_ff),
      .step          (step),
      .result        (result)
   );

   utf8sd_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (advance && step.have),
      .result           (result),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_truncated    (rsp_truncated),
      .rsp_final_result (rsp_final_result)
   );

   `UTF8SD_ASSERT_NOW(a_owed_range, clock, reset, 1'b1, owed_ff <= OWED_FIVE,
      "owed count out of range")
   `UTF8SD_ASSERT_NOW(a_trunc_zero, clock, reset, rsp_valid && rsp_truncated,
      rsp_code_point == 31'd0 && rsp_final_result, "truncated word not zero and final")
   `UTF8SD_ASSERT_NEXT(a_end_clears, clock, reset, advance && last_ff,
      owed_ff == OWED_NONE && gathered_ff == 31'd0, "state not clear after buffer end")
   `UTF8SD_ASSERT_NEXT(a_result_shown, clock, reset, advance && step.have, rsp_valid,
      "produced word not presented")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the UTF-8 stream decoder: random and directed byte streams checked against a decoder model.
`timescale 1ns / 100ps

module testbench;
   import utf8sd_pkg::*;

   localparam int STREAM_BYTES   = 1650;
   localparam int TAIL_BYTES     = 150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 90;
   localparam int LONG_HOLD_AT   = 600;

   typedef struct {
      logic [7:0] value;
      logic       last;
      logic       wait_drain;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'd0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [30:0] rsp_code_point;
   logic        rsp_truncated;
   logic        rsp_final_result;

   stream_byte_type   byte_stream[$];
   utf8sd_result_type expected_chars[$];

   logic [2:0]  owed_count = OWED_NONE;
   logic [30:0] gathered_acc = '0;

   int failures = 0;
   int words_taken = 0;
   int send_gap = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int random_count = 0;
   bit idle_enabled = 1'b1;
   bit long_hold_done = 1'b0;
   utf8sd_result_type decoded;
   utf8sd_result_type want;
   stream_byte_type   next_byte;

   utf8_stream_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_truncated    (rsp_truncated),
      .rsp_final_result (rsp_final_result)
   );

   always #2 clock = ~clock;

   function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                        output utf8sd_result_type r);
      logic got;
      got = 1'b0;
      r = '0;
      if (owed_count == OWED_NONE) begin
         if ((b & LEAD6_MASK) == LEAD6_CODE) begin
            owed_count = OWED_FIVE;
            gathered_acc = 31'(b[0]);
         end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
            owed_count = OWED_FOUR;
            gathered_acc = 31'(b[1:0]);
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            owed_count = OWED_THREE;
            gathered_acc = 31'(b[2:0]);
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            owed_count = OWED_TWO;
            gathered_acc = 31'(b[3:0]);
         end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            owed_count = OWED_ONE;
            gathered_acc = 31'(b[4:0]);
         end else begin
            got = 1'b1;
            r.code_point = 31'(b);
         end
      end else begin
         gathered_acc = {gathered_acc[24:0], b[5:0]};
         owed_count = owed_count - 3'd1;
         if (owed_count == OWED_NONE) begin
            got = 1'b1;
            r.code_point = gathered_acc;
            gathered_acc = '0;
         end
      end
      if (got) begin
         r.final_result = last;
      end else if (last) begin
         owed_count = OWED_NONE;
         gathered_acc = '0;
         r.truncated = 1'b1;
         r.final_result = 1'b1;
         got = 1'b1;
      end
      return got;
   endfunction

   task automatic add_byte(input logic [7:0] value, input logic last = 1'b0,
                           input logic wait_drain = 1'b0);
      stream_byte_type w;
      w.value = value;
      w.last = last;
      w.wait_drain = wait_drain;
      byte_stream.push_back(w);
   endtask

   task automatic add_sequence(input int len, input logic wait_drain);
      logic [7:0] lead;
      case (len)
         1: lead = 8'($urandom_range(0, 127));
         2: lead = {3'b110, 5'($urandom)};
         3: lead = {4'b1110, 4'($urandom)};
         4: lead = {5'b11110, 3'($urandom)};
         5: lead = {6'b111110, 2'($urandom)};
         default: lead = {7'b1111110, 1'($urandom)};
      endcase
      add_byte(lead, $urandom_range(0, 39) == 0, wait_drain);
      for (int i = 1; i < len; i++) begin
         if ($urandom_range(0, 11) == 0)
            add_byte(8'($urandom), $urandom_range(0, 39) == 0);
         else
            add_byte({2'b10, 6'($urandom)}, $urandom_range(0, 39) == 0);
      end
      random_count += len;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (decode_byte(req_byte_in, req_end_of_buffer, decoded))
               expected_chars.push_back(decoded);
            words_taken++;
            if (words_taken % 64 == 0)
               idle_enabled = $urandom_range(0, 2) != 0;
            if (byte_stream.size() >= TAIL_BYTES && idle_enabled && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 6);
         end
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (byte_stream.size() == 0) begin
            req_valid <= 1'b0;
         end else if (byte_stream[0].wait_drain && expected_chars.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            next_byte = byte_stream.pop_front();
            req_byte_in <= next_byte.value;
            req_end_of_buffer <= next_byte.last;
            req_valid <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected result: code_point %h truncated %b final_result %b",
                      rsp_code_point, rsp_truncated, rsp_final_result);
               failures++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point: expected %h, got %h", want.code_point, rsp_code_point);
                  failures++;
               end
               if (rsp_truncated !== want.truncated) begin
                  $error("truncated: expected %b, got %b", want.truncated, rsp_truncated);
                  failures++;
               end
               if (rsp_final_result !== want.final_result) begin
                  $error("final_result: expected %b, got %b",
                         want.final_result, rsp_final_result);
                  failures++;
               end
            end
         end
         if (!long_hold_done && words_taken >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left == 0 && byte_stream.size() >= TAIL_BYTES && idle_enabled
             && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      add_byte(8'h00);
      add_byte(8'h7f, 1'b1);
      add_byte(8'h80);
      add_byte(8'hbf);
      add_byte(8'hfe);
      add_byte(8'hff);
      add_byte(8'hc2);
      add_byte(8'ha9);
      add_byte(8'hef);
      add_byte(8'hff);
      add_byte(8'h00);
      add_byte(8'hf0);
      add_byte(8'h9f);
      add_byte(8'h98);
      add_byte(8'h80);
      add_byte(8'hf8);
      add_byte(8'h88);
      add_byte(8'h80);
      add_byte(8'h80);
      add_byte(8'h80);
      add_byte(8'hfd);
      for (int i = 0; i < 5; i++)
         add_byte(8'hbf, i == 4);
      add_byte(8'he0, 1'b1);
      add_byte(8'hf0);
      add_byte(8'h80, 1'b1);

      while (random_count < STREAM_BYTES) begin
         if ($urandom_range(0, 9) == 0) begin
            add_byte(8'($urandom), $urandom_range(0, 39) == 0);
            random_count++;
         end else begin
            add_sequence($urandom_range(1, 6),
                         random_count == 0 || (random_count >= 400 && random_count < 406)
                         || (random_count >= 1200 && random_count < 1206));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (byte_stream.size() != 0 || req_valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (failures == 0 && expected_chars.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/utf8sd_pkg.sv
rtl/utf8sd_decode.sv
rtl/utf8sd_rsp_reg.sv
rtl/utf8_stream_decoder_unit.sv
test/testbench.sv
